// File: rtl/core/scp_pkg.sv
`default_nettype none
package scp_pkg;

	localparam int COORD_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// register indexes of the configuration port
	localparam logic [1:0] REG_END_A_X = 2'd0;
	localparam logic [1:0] REG_END_A_Y = 2'd1;
	localparam logic [1:0] REG_END_B_X = 2'd2;
	localparam logic [1:0] REG_END_B_Y = 2'd3;

	// reset values of the endpoints (b is 1.0, 1.0 in q16.16)
	localparam longint RESET_A = 0;
	localparam longint RESET_B = 65536;

	// clamp kinds
	localparam logic [1:0] KIND_INTERIOR = 2'd0;
	localparam logic [1:0] KIND_END_A    = 2'd1;
	localparam logic [1:0] KIND_END_B    = 2'd2;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
	} ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/scp_front.sv
`default_nettype none
module scp_front #(
	parameter int COORD_WIDTH = scp_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_a_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_a_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_b_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_b_y,
	output scp_pkg::ctl_t                      ctl_o,
	output logic [2*COORD_WIDTH+2:0]           rem_o,
	output logic [2*COORD_WIDTH+2:0]           den_o
);
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int NW = 2 * COORD_WIDTH + 3;

	logic              v_s1, v_s2, v_s3;
	logic signed [DW-1:0] px_s1, py_s1, dx_s1, dy_s1;
	logic signed [PW-1:0] pdx_s2, pdy_s2, ddx_s2, ddy_s2;
	logic signed [NW-1:0] num_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// exact differences
			px_s1  <= DW'(point_x) - DW'(end_a_x);
			py_s1  <= DW'(point_y) - DW'(end_a_y);
			dx_s1  <= DW'(end_b_x) - DW'(end_a_x);
			dy_s1  <= DW'(end_b_y) - DW'(end_a_y);
			pdx_s2 <= PW'(px_s1) * PW'(dx_s1);
			pdy_s2 <= PW'(py_s1) * PW'(dy_s1);
			ddx_s2 <= PW'(dx_s1) * PW'(dx_s1);
			ddy_s2 <= PW'(dy_s1) * PW'(dy_s1);
			num_s3 <= NW'(pdx_s2) + NW'(pdy_s2);
			den_s3 <= NW'(ddx_s2) + NW'(ddy_s2);
		end
	end

	always_comb begin
		ctl_o.valid = v_s3;
		if (num_s3 <= 0) begin
			ctl_o.kind = scp_pkg::KIND_END_A;
		end else if (num_s3 >= den_s3) begin
			ctl_o.kind = scp_pkg::KIND_END_B;
		end else begin
			ctl_o.kind = scp_pkg::KIND_INTERIOR;
		end
	end

	assign rem_o = num_s3;
	assign den_o = den_s3;

endmodule
`default_nettype wire

// File: rtl/core/scp_div_cell.sv
`default_nettype none
module scp_div_cell #(
	parameter int REM_WIDTH     = 2 * scp_pkg::COORD_WIDTH_DEF + 3,
	parameter int FRACTION_BITS = scp_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire scp_pkg::ctl_t            ctl_i,
	input  wire logic [REM_WIDTH-1:0]     rem_i,
	input  wire logic [REM_WIDTH-1:0]     den_i,
	input  wire logic [FRACTION_BITS-1:0] lam_i,
	output scp_pkg::ctl_t                 ctl_q,
	output logic [REM_WIDTH-1:0]          rem_q,
	output logic [REM_WIDTH-1:0]          den_q,
	output logic [FRACTION_BITS-1:0]      lam_q
);
	logic [REM_WIDTH-1:0] shifted;
	logic                 fits;

	// one restoring step: shift, trial compare, subtract
	assign shifted = {rem_i[REM_WIDTH-2:0], 1'b0};
	assign fits    = (shifted >= den_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fits ? shifted - den_i : shifted;
			den_q <= den_i;
			lam_q <= {lam_i[FRACTION_BITS-2:0], fits};
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/scp_back.sv
`default_nettype none
module scp_back #(
	parameter int COORD_WIDTH   = scp_pkg::COORD_WIDTH_DEF,
	parameter int FRACTION_BITS = scp_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire scp_pkg::ctl_t                 ctl_i,
	input  wire logic [FRACTION_BITS-1:0]      lam_i,
	input  wire logic signed [COORD_WIDTH-1:0] end_a_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_a_y,
	input  wire logic signed [COORD_WIDTH-1:0] end_b_x,
	input  wire logic signed [COORD_WIDTH-1:0] end_b_y,
	output scp_pkg::ctl_t                      ctl_o,
	output logic [COORD_WIDTH-1:0]             near_x,
	output logic [COORD_WIDTH-1:0]             near_y
);
	localparam int DW = COORD_WIDTH + 1;
	localparam int MW = FRACTION_BITS + 1 + DW;

	logic signed [DW-1:0] dx, dy;
	logic signed [MW-1:0] mx_s1, my_s1;
	scp_pkg::ctl_t        ctl_s1;

	assign dx = DW'(end_b_x) - DW'(end_a_x);
	assign dy = DW'(end_b_y) - DW'(end_a_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= MW'($signed({1'b0, lam_i})) * MW'(dx);
			my_s1 <= MW'($signed({1'b0, lam_i})) * MW'(dy);
		end
	end

	always_comb begin
		ctl_o = ctl_s1;
		case (ctl_s1.kind)
			scp_pkg::KIND_END_A: begin
				near_x = end_a_x;
				near_y = end_a_y;
			end
			scp_pkg::KIND_END_B: begin
				near_x = end_b_x;
				near_y = end_b_y;
			end
			default: begin
				// floor shift of lambda * d, added to a
				near_x = end_a_x + mx_s1[FRACTION_BITS+COORD_WIDTH-1:FRACTION_BITS];
				near_y = end_a_y + my_s1[FRACTION_BITS+COORD_WIDTH-1:FRACTION_BITS];
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/segment_closest_point.sv
// throughput: one beat per cycle while in_stall is low, set by the chain of
// one-bit divider cells (one restoring step per cell, FRACTION_BITS cells)
// and two multiplier stages
// reset: arst_n clears all valid bits and loads the endpoints a = (0, 0), b = (1.0, 1.0)
`default_nettype none
module segment_closest_point #(
	parameter int COORD_WIDTH   = scp_pkg::COORD_WIDTH_DEF,
	parameter int FRACTION_BITS = scp_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_wr_en,
	input  wire logic [1:0]                    cfg_addr,
	input  wire logic [COORD_WIDTH-1:0]        cfg_wdata,
	// query point channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0]      near_x,
	output logic signed [COORD_WIDTH-1:0]      near_y,
	output logic [1:0]                         clamp_kind
);
	localparam int NW = 2 * COORD_WIDTH + 3;

	logic signed [COORD_WIDTH-1:0] end_a_x_q, end_a_y_q, end_b_x_q, end_b_y_q;

	// endpoint registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_a_x_q <= COORD_WIDTH'(scp_pkg::RESET_A);
			end_a_y_q <= COORD_WIDTH'(scp_pkg::RESET_A);
			end_b_x_q <= COORD_WIDTH'(scp_pkg::RESET_B);
			end_b_y_q <= COORD_WIDTH'(scp_pkg::RESET_B);
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				scp_pkg::REG_END_A_X: end_a_x_q <= cfg_wdata;
				scp_pkg::REG_END_A_Y: end_a_y_q <= cfg_wdata;
				scp_pkg::REG_END_B_X: end_b_x_q <= cfg_wdata;
				scp_pkg::REG_END_B_Y: end_b_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// the whole pipe moves together unless the skid stage is holding a beat
	logic skid_valid_q;
	logic en;
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// front end: differences, products, numerator and denominator, clamp decision
	scp_pkg::ctl_t        ctl_c   [0:FRACTION_BITS];
	logic [NW-1:0]        rem_c   [0:FRACTION_BITS];
	logic [NW-1:0]        den_c   [0:FRACTION_BITS];
	logic [FRACTION_BITS-1:0] lam_c [0:FRACTION_BITS];

	scp_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.point_x (point_x),
		.point_y (point_y),
		.end_a_x (end_a_x_q),
		.end_a_y (end_a_y_q),
		.end_b_x (end_b_x_q),
		.end_b_y (end_b_y_q),
		.ctl_o   (ctl_c[0]),
		.rem_o   (rem_c[0]),
		.den_o   (den_c[0])
	);

	assign lam_c[0] = '0;

	// chain of divider cells, each producing one bit of lambda
	for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_cell
		scp_div_cell #(
			.REM_WIDTH    (NW),
			.FRACTION_BITS(FRACTION_BITS)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_i (ctl_c[i]),
			.rem_i (rem_c[i]),
			.den_i (den_c[i]),
			.lam_i (lam_c[i]),
			.ctl_q (ctl_c[i+1]),
			.rem_q (rem_c[i+1]),
			.den_q (den_c[i+1]),
			.lam_q (lam_c[i+1])
		);
	end

	// back end: scale d by lambda and pick the answer
	scp_pkg::ctl_t          res_ctl;
	logic [COORD_WIDTH-1:0] res_x, res_y;

	scp_back #(
		.COORD_WIDTH  (COORD_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_c[FRACTION_BITS]),
		.lam_i  (lam_c[FRACTION_BITS]),
		.end_a_x(end_a_x_q),
		.end_a_y(end_a_y_q),
		.end_b_x(end_b_x_q),
		.end_b_y(end_b_y_q),
		.ctl_o  (res_ctl),
		.near_x (res_x),
		.near_y (res_y)
	);

	// output register with a skid stage behind it
	logic                   out_valid_q;
	logic [COORD_WIDTH-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
	logic [1:0]             out_kind_q, skid_kind_q;
	logic                   take;

	assign take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q  <= skid_valid_q || res_ctl.valid;
			skid_valid_q <= 1'b0;
		end else if (en && res_ctl.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_x_q    <= skid_valid_q ? skid_x_q : res_x;
			out_y_q    <= skid_valid_q ? skid_y_q : res_y;
			out_kind_q <= skid_valid_q ? skid_kind_q : res_ctl.kind;
		end else if (en) begin
			skid_x_q    <= res_x;
			skid_y_q    <= res_y;
			skid_kind_q <= res_ctl.kind;
		end
	end

	assign out_valid  = out_valid_q;
	assign near_x     = out_x_q;
	assign near_y     = out_y_q;
	assign clamp_kind = out_kind_q;

	// a held skid beat always has an output beat ahead of it
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid beat without output beat");

	// the skid stage only fills when the output is stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled while output free");

	// no clamp code outside the three kinds
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_kind_q == scp_pkg::KIND_INTERIOR ||
			out_kind_q == scp_pkg::KIND_END_A || out_kind_q == scp_pkg::KIND_END_B))
		else $error("illegal clamp kind");

	// a beat clamped to a carries endpoint a
	a_clamp_a: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == scp_pkg::KIND_END_A) |->
		(out_x_q == end_a_x_q && out_y_q == end_a_y_q))
		else $error("clamp to a with wrong point");

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;

	localparam int CW       = 32;
	localparam int FB       = 16;
	localparam int LATENCY  = FB + 5;
	localparam int WD_LIMIT = 4000;

	// expected nearest point for one query beat
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [1:0]           kind;
	} near_t;

	// scoreboard: holds the projection answers still owed by the block
	class near_board;
		near_t owed[$];
		int    errors;

		function void note_query(near_t n);
			owed.push_back(n);
		endfunction

		function void check_result(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
				logic [1:0] k);
			near_t e;
			if (owed.size() == 0) begin
				$error("result beat with nothing owed: %h %h %0d", x, y, k);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (x !== e.x) begin
				$error("near_x expected %h actual %h", e.x, x);
				errors++;
			end
			if (y !== e.y) begin
				$error("near_y expected %h actual %h", e.y, y);
				errors++;
			end
			if (k !== e.kind) begin
				$error("clamp_kind expected %0d actual %0d", e.kind, k);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_addr;
	logic [CW-1:0] cfg_wdata;
	logic in_valid, in_stall;
	logic signed [CW-1:0] point_x, point_y;
	logic out_valid, out_stall;
	logic signed [CW-1:0] near_x, near_y;
	logic [1:0] clamp_kind;

	segment_closest_point dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .point_x(point_x), .point_y(point_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.near_x(near_x), .near_y(near_y), .clamp_kind(clamp_kind)
	);

	near_board board = new();

	// local copy of the segment endpoints
	logic signed [CW-1:0] seg_ax, seg_ay, seg_bx, seg_by;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// projection of p onto segment a-b, full width products, truncated lambda
	function automatic near_t project(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy);
		logic signed [CW:0]       dx, dy, px, py;
		logic signed [2*CW+3:0]   num, den, rem;
		logic [FB-1:0]            lam;
		logic signed [CW+FB+2:0]  offx, offy;
		near_t r;
		dx  = $signed({seg_bx[CW-1], seg_bx}) - $signed({seg_ax[CW-1], seg_ax});
		dy  = $signed({seg_by[CW-1], seg_by}) - $signed({seg_ay[CW-1], seg_ay});
		px  = $signed({qx[CW-1], qx}) - $signed({seg_ax[CW-1], seg_ax});
		py  = $signed({qy[CW-1], qy}) - $signed({seg_ay[CW-1], seg_ay});
		num = px * dx + py * dy;
		den = dx * dx + dy * dy;
		if (num <= 0) begin
			r = '{seg_ax, seg_ay, scp_pkg::KIND_END_A};
		end else if (num >= den) begin
			r = '{seg_bx, seg_by, scp_pkg::KIND_END_B};
		end else begin
			// restoring division, one quotient bit per step
			rem = num;
			lam = '0;
			for (int i = 0; i < FB; i++) begin
				rem = rem <<< 1;
				lam = lam << 1;
				if (rem >= den) begin
					rem    = rem - den;
					lam[0] = 1'b1;
				end
			end
			offx = ($signed({1'b0, lam}) * dx) >>> FB;
			offy = ($signed({1'b0, lam}) * dy) >>> FB;
			r = '{CW'(seg_ax + offx), CW'(seg_ay + offy), scp_pkg::KIND_INTERIOR};
		end
		return r;
	endfunction

	// register write, only while the pipe is drained
	task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			scp_pkg::REG_END_A_X: seg_ax = val;
			scp_pkg::REG_END_A_Y: seg_ay = val;
			scp_pkg::REG_END_B_X: seg_bx = val;
			default:              seg_by = val;
		endcase
	endtask

	task automatic set_segment(logic [CW-1:0] ax, logic [CW-1:0] ay,
			logic [CW-1:0] bx, logic [CW-1:0] by);
		write_reg(scp_pkg::REG_END_A_X, ax);
		write_reg(scp_pkg::REG_END_A_Y, ay);
		write_reg(scp_pkg::REG_END_B_X, bx);
		write_reg(scp_pkg::REG_END_B_Y, by);
		cfg_wr_en <= 1'b0;
	endtask

	// one query beat; valid stays up across back-to-back beats
	task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, bit hold);
		in_valid <= 1'b1;
		point_x  <= x;
		point_y  <= y;
		do @(posedge clk); while (in_stall);
		board.note_query(project(x, y));
		if (!hold) in_valid <= 1'b0;
	endtask

	task automatic drain;
		wait (board.owed.size() == 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// random coordinate: full range, small values, or near endpoint a
	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return CW'($signed($urandom_range(8 << 16)) - (4 << 16));
			2: return {{(CW-1){1'($urandom_range(1))}}, 1'($urandom_range(1))};
			default: return seg_ax + CW'($signed($urandom_range(4096)) - 2048);
		endcase
	endfunction

	task automatic random_burst(int count);
		int left, len;
		left = count;
		while (left > 0) begin
			len = $urandom_range(1, 24);
			if (len > left) len = left;
			for (int i = 0; i < len; i++) begin
				logic [CW-1:0] x, y;
				// mostly points along the segment line so the interior path is hit
				if ($urandom_range(2) != 0) begin
					x = seg_ax + ((seg_bx - seg_ax) >>> $urandom_range(1, 3))
						+ CW'($signed($urandom_range(512)) - 256);
					y = seg_ay + ((seg_by - seg_ay) >>> $urandom_range(1, 3))
						+ CW'($signed($urandom_range(512)) - 256);
				end else begin
					x = rand_coord();
					y = rand_coord();
				end
				send_point(x, y, i != len - 1);
			end
			left -= len;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// receiver stall pattern: stretches of random stalls and free-running runs
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(15) == 0) begin
				repeat ($urandom_range(5, 40)) begin
					out_stall <= 1'b0;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(2) == 0);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(near_x, near_y, clamp_kind);
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0; cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wdata = '0;
		in_valid = 1'b0; point_x = '0; point_y = '0;
		seg_ax = CW'(scp_pkg::RESET_A); seg_ay = CW'(scp_pkg::RESET_A);
		seg_bx = CW'(scp_pkg::RESET_B); seg_by = CW'(scp_pkg::RESET_B);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset segment, both clamps, interior, lambda truncating to zero
		send_point('0, '0, 1);
		send_point(32'h0001_0000, 32'h0001_0000, 1);
		send_point(32'h0000_8000, 32'h0000_8000, 1);
		send_point(32'h0000_0001, 32'h0000_0000, 1);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 1);
		send_point(32'h8000_0000, 32'h8000_0000, 1);
		send_point(32'h8000_0000, 32'h7fff_ffff, 1);
		send_point(32'h0000_c000, 32'h0000_4000, 0);
		drain();
		// the full-range diagonal, extremes of every coordinate
		set_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h0000_0000, 32'h0000_0000, 1);
		send_point(32'h7fff_ffff, 32'h8000_0000, 1);
		send_point(32'h8000_0000, 32'h8000_0000, 1);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 1);
		send_point(32'h1234_5678, 32'hfedc_ba98, 0);
		drain();
		// degenerate segment gives endpoint a
		set_segment(32'h0003_0000, 32'hfffd_0000, 32'h0003_0000, 32'hfffd_0000);
		send_point(32'h7fff_ffff, 32'h8000_0000, 1);
		send_point(32'h0003_0000, 32'hfffd_0000, 0);
		drain();
		// reversed extremes
		set_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_point(32'h0000_0000, 32'h0000_0000, 1);
		send_point(32'hffff_ffff, 32'h0000_0001, 0);
		drain();

		// random phases over a range of segments
		for (int ph = 0; ph < 9; ph++) begin
			case (ph % 3)
				0: set_segment($urandom(), $urandom(), $urandom(), $urandom());
				1: set_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
				default: set_segment(CW'($signed($urandom_range(1 << 20)) - (1 << 19)),
					CW'($signed($urandom_range(1 << 20)) - (1 << 19)),
					CW'($signed($urandom_range(1 << 20)) - (1 << 19)),
					CW'($signed($urandom_range(1 << 20)) - (1 << 19)));
			endcase
			random_burst(50);
			// sender holds off until the pipe has emptied
			wait (board.owed.size() == 0);
			random_burst(55);
			drain();
		end

		drain();
		if (board.errors == 0 && board.owed.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
